@@ src/lfid_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the lowest-free ID allocator.
// No dependencies; used by the controller, datapath, top level and checker.
package lfid_pkg;

  localparam int MAX_IDS   = 256;
  localparam int ID_W      = 9;
  localparam int CNT_W     = 9;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 16;
  localparam int NUM_WORDS = MAX_IDS / WORD_W;
  localparam int WIDX_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int MAP_W     = WIDX_W + BIT_W;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic find;
    logic commit;
  } lfid_cmd_t;

  // Index of the lowest clear bit in a bitmap word.
  function automatic logic [BIT_W-1:0] lowest_zero_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest word whose full flag is clear.
  function automatic logic [WIDX_W-1:0] lowest_zero_word(input logic [NUM_WORDS-1:0] v);
    logic [WIDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!v[i]) idx = WIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/lfid_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the allocator: steps one transaction through lookup, find, commit.
// Depends on lfid_pkg for the command struct.
module lfid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output lfid_pkg::lfid_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_FIND   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_FIND;
      S_FIND:   state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.lookup  = (state_r == S_LOOKUP);
  assign cmd.find    = (state_r == S_FIND);
  assign cmd.commit  = (state_r == S_COMMIT);

endmodule

@@ src/lfid_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the allocator: in-use bitmap, full flags, use count and result registers.
// Depends on lfid_pkg; driven by commands from lfid_ctrl.
module lfid_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfid_pkg::lfid_cmd_t               cmd,
  input  logic                              in_op,
  input  logic [lfid_pkg::ID_W-1:0]         in_id,
  output logic                              out_valid,
  output logic [lfid_pkg::ID_W-1:0]         out_granted_id,
  output logic [lfid_pkg::STATUS_W-1:0]     out_status,
  output logic [lfid_pkg::CNT_W-1:0]        out_in_use_count
);

  logic                            op_r;
  logic [lfid_pkg::ID_W-1:0]       id_r;
  logic [lfid_pkg::WORD_W-1:0]     map_r [lfid_pkg::NUM_WORDS];
  logic [lfid_pkg::NUM_WORDS-1:0]  full_r;
  logic [lfid_pkg::CNT_W-1:0]      count_r;
  logic [lfid_pkg::WIDX_W-1:0]     widx_r;
  logic [lfid_pkg::WORD_W-1:0]     word_r;
  logic [lfid_pkg::BIT_W-1:0]      bidx_r;
  logic                            err_r;
  logic                            valid_r;
  logic [lfid_pkg::ID_W-1:0]       granted_r;
  logic [lfid_pkg::STATUS_W-1:0]   status_r;

  logic [lfid_pkg::ID_W-1:0]       id_m1;
  logic                            id_bad;
  logic [lfid_pkg::WIDX_W-1:0]     widx_nxt;
  logic                            err_lookup;
  logic [lfid_pkg::BIT_W-1:0]      bidx_nxt;
  logic                            err_find;
  logic [lfid_pkg::WORD_W-1:0]     word_upd;
  logic [lfid_pkg::CNT_W-1:0]      count_nxt;

  assign id_m1  = id_r - lfid_pkg::ID_W'(1);
  assign id_bad = (id_r == '0) || (id_r > lfid_pkg::ID_W'(lfid_pkg::MAX_IDS));

  always_comb begin
    if (op_r == lfid_pkg::OP_ALLOC) begin
      widx_nxt   = lfid_pkg::lowest_zero_word(full_r);
      err_lookup = (count_r >= lfid_pkg::CNT_W'(lfid_pkg::MAX_IDS));
    end else begin
      widx_nxt   = id_m1[lfid_pkg::MAP_W-1:lfid_pkg::BIT_W];
      err_lookup = id_bad;
    end
  end

  always_comb begin
    if (op_r == lfid_pkg::OP_ALLOC) begin
      bidx_nxt = lfid_pkg::lowest_zero_bit(word_r);
      err_find = err_r;
    end else begin
      bidx_nxt = id_m1[lfid_pkg::BIT_W-1:0];
      err_find = err_r || !word_r[bidx_nxt];
    end
  end

  always_comb begin
    word_upd = word_r;
    word_upd[bidx_r] = (op_r == lfid_pkg::OP_ALLOC);
    if (err_r) begin
      count_nxt = count_r;
    end else if (op_r == lfid_pkg::OP_ALLOC) begin
      count_nxt = count_r + lfid_pkg::CNT_W'(1);
    end else begin
      count_nxt = count_r - lfid_pkg::CNT_W'(1);
    end
  end

  // Request capture and search pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      id_r <= in_id;
    end
    if (cmd.lookup) begin
      widx_r <= widx_nxt;
      word_r <= map_r[widx_nxt];
      err_r  <= err_lookup;
    end
    if (cmd.find) begin
      bidx_r <= bidx_nxt;
      err_r  <= err_find;
    end
    if (cmd.commit) begin
      if (op_r == lfid_pkg::OP_ALLOC && !err_r) begin
        granted_r <= lfid_pkg::ID_W'({widx_r, bidx_r}) + lfid_pkg::ID_W'(1);
      end else begin
        granted_r <= '0;
      end
      if (!err_r) begin
        status_r <= lfid_pkg::ST_OK;
      end else if (op_r == lfid_pkg::OP_ALLOC) begin
        status_r <= lfid_pkg::ST_EXHAUSTED;
      end else begin
        status_r <= lfid_pkg::ST_NOT_IN_USE;
      end
    end
  end

  // Bitmap, full flags and count: cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < lfid_pkg::NUM_WORDS; w++) begin
        map_r[w] <= '0;
      end
      full_r  <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.commit;
      if (cmd.commit && !err_r) begin
        map_r[widx_r]  <= word_upd;
        full_r[widx_r] <= &word_upd;
        count_r        <= count_nxt;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_granted_id   = granted_r;
  assign out_status       = status_r;
  assign out_in_use_count = count_r;

endmodule

@@ src/lowest_free_id_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the lowest-free ID allocator: controller plus datapath.
// Depends on lfid_pkg, lfid_ctrl and lfid_datapath.
//
// Usage:
//   Drive in_op (allocate or release) and in_id, and raise start. The
//   transaction is taken at the rising edge where start is high and busy is
//   low. Allocate grants the lowest free ID in 1..MAX_IDS; release frees in_id.
//
//   Each transaction steps through capture, word lookup over the full flags
//   of the 16-bit bitmap words, bit search inside the chosen word, and commit
//   back to the bitmap. A new transaction is taken only once the previous
//   one has reached commit.
//
//   The result is registered at commit and shows on the out_ ports for
//   exactly one cycle, marked by out_valid; busy is already low then, so
//   the next transaction may be taken in that same cycle. The receiver has
//   no way to stall; it must take each result when out_valid is high.
//
//   Reset (rst_n low, synchronous) clears every in-use bit and the count at
//   once; no clearing pass is needed, start may be raised right after.
//   Errors (exhausted, release of a free or out-of-range ID) leave state as is.
module lowest_free_id_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [lfid_pkg::ID_W-1:0]         in_id,
  output logic                              out_valid,
  output logic [lfid_pkg::ID_W-1:0]         out_granted_id,
  output logic [lfid_pkg::STATUS_W-1:0]     out_status,
  output logic [lfid_pkg::CNT_W-1:0]        out_in_use_count
);

  // Command bundle from the sequencer into the datapath
  lfid_pkg::lfid_cmd_t cmd;

  lfid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the bitmap, search it and register the result
  lfid_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_id            (in_id),
    .out_valid        (out_valid),
    .out_granted_id   (out_granted_id),
    .out_status       (out_status),
    .out_in_use_count (out_in_use_count)
  );

endmodule

@@ src/lfid_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the allocator, bound to the top level.
// Depends on lfid_pkg and lowest_free_id_allocator.
module lfid_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [lfid_pkg::ID_W-1:0]         out_granted_id,
  input logic [lfid_pkg::STATUS_W-1:0]     out_status,
  input logic [lfid_pkg::CNT_W-1:0]        out_in_use_count
);

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result did not appear four cycles after accept");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a transaction is in flight");

  a_exhausted_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == lfid_pkg::ST_EXHAUSTED) |->
      (out_in_use_count == lfid_pkg::CNT_W'(lfid_pkg::MAX_IDS)))
    else $error("exhausted status with free IDs left");

  a_error_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != lfid_pkg::ST_OK) |-> (out_granted_id == '0))
    else $error("ID granted on a failed transaction");

endmodule

bind lowest_free_id_allocator lfid_checker u_lfid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_granted_id   (out_granted_id),
  .out_status       (out_status),
  .out_in_use_count (out_in_use_count)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the lowest-free ID allocator.
// Depends on lfid_pkg and lowest_free_id_allocator; a negedge driver feeds
// requests from a queue, a posedge monitor predicts and checks every result.
module tb_top;
  import lfid_pkg::*;

  // One queued request, with its idle gap before it is offered and a flag
  // that holds the sender off until every outstanding result has come back.
  typedef struct {
    logic            op;
    logic [ID_W-1:0] id;
    int              gap;
    bit              quiesce;
  } id_request_t;

  // What the allocator must report for one transaction.
  typedef struct {
    logic [ID_W-1:0]     granted;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_op = OP_ALLOC;
  logic [ID_W-1:0]     in_id = '0;
  logic                out_valid;
  logic [ID_W-1:0]     out_granted_id;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_in_use_count;

  id_request_t   request_q[$];
  alloc_result_t expected_result_q[$];

  // Own copy of the allocator state: one bit per ID plus the count in use.
  bit model_in_use [1:MAX_IDS];
  int model_count = 0;

  int  total_requests = 0;
  int  accepted_count = 0;
  int  error_count = 0;
  int  grant_count = 0;
  int  exhausted_count = 0;
  int  not_in_use_count = 0;
  int  peak_in_use = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  accept_seen = 1'b0;

  lowest_free_id_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_id            (in_id),
    .out_valid        (out_valid),
    .out_granted_id   (out_granted_id),
    .out_status       (out_status),
    .out_in_use_count (out_in_use_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one accepted transaction and advance the state.
  // Allocate takes the lowest clear bit; release of ID 0, of an ID above
  // MAX_IDS or of a free ID is refused and leaves the state alone.
  function automatic void predict_request(input logic op, input logic [ID_W-1:0] id);
    alloc_result_t r;
    int            idx;
    r.granted = '0;
    r.status  = ST_OK;
    if (op == OP_ALLOC) begin
      if (model_count >= MAX_IDS) begin
        r.status = ST_EXHAUSTED;
      end else begin
        idx = 1;
        while (model_in_use[idx]) idx++;
        model_in_use[idx] = 1'b1;
        model_count++;
        r.granted = ID_W'(idx);
      end
    end else begin
      idx = int'(id);
      if (idx == 0 || idx > MAX_IDS) begin
        r.status = ST_NOT_IN_USE;
      end else if (!model_in_use[idx]) begin
        r.status = ST_NOT_IN_USE;
      end else begin
        model_in_use[idx] = 1'b0;
        model_count--;
      end
    end
    r.count = CNT_W'(model_count);
    expected_result_q.push_back(r);
  endfunction

  // Queue one request. Idle gaps are drawn at random, except inside bursts
  // of back-to-back transactions that start now and then.
  task automatic queue_request(input logic op, input logic [ID_W-1:0] id,
                               input bit quiesce = 1'b0);
    id_request_t q;
    q.op      = op;
    q.id      = id;
    q.quiesce = quiesce;
    if (burst_left > 0) begin
      burst_left--;
      q.gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      q.gap = 0;
    end else begin
      q.gap = $urandom_range(0, 14);
    end
    request_q.push_back(q);
  endtask

  // One round of well-formed traffic: fill the map to exhaustion, churn near
  // the top, drain it with a shuffled sweep of every ID, then plain noise.
  task automatic queue_round();
    int perm [MAX_IDS];
    int j;
    int tmp;
    // Fill: almost all allocates, with stray releases anywhere in 0..511.
    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(0, 15) != 0) queue_request(OP_ALLOC, ID_W'($urandom));
      else queue_request(OP_RELEASE, ID_W'($urandom));
    end
    // Churn: even mix, releases mostly aimed at valid IDs.
    for (int k = 0; k < 200; k++) begin
      if ($urandom_range(0, 1) == 0) queue_request(OP_ALLOC, ID_W'($urandom));
      else if ($urandom_range(0, 7) == 0) queue_request(OP_RELEASE, ID_W'($urandom));
      else queue_request(OP_RELEASE, ID_W'($urandom_range(1, MAX_IDS)));
    end
    // Drain: every ID once in random order, a few allocates in between.
    for (int k = 0; k < MAX_IDS; k++) perm[k] = k + 1;
    for (int k = MAX_IDS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    for (int k = 0; k < MAX_IDS; k++) begin
      if ($urandom_range(0, 7) == 0) queue_request(OP_ALLOC, ID_W'($urandom));
      // Hold the sender at the start of the drain until the block is quiet.
      queue_request(OP_RELEASE, ID_W'(perm[k]), k == 0);
    end
    // Noise: any op, any 9-bit ID.
    for (int k = 0; k < 60; k++) begin
      queue_request(logic'($urandom_range(0, 1)), ID_W'($urandom));
    end
  endtask

  // Driver: change inputs only at the falling edge. Drop start once the
  // transaction has been taken, or keep it high straight into the next one
  // when that one has no gap; start gets one assignment per edge.
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (accept_seen) begin
        accept_seen = 1'b0;
        nxt_start   = 1'b0;
        idle_cycles = 0;
      end
      if (!nxt_start && request_q.size() != 0) begin
        if (idle_cycles >= request_q[0].gap &&
            !(request_q[0].quiesce && expected_result_q.size() != 0)) begin
          in_op       <= request_q[0].op;
          in_id       <= request_q[0].id;
          nxt_start   = 1'b1;
          void'(request_q.pop_front());
        end else begin
          idle_cycles++;
        end
      end
    end
    start <= nxt_start;
  end

  // Monitor: sample at the rising edge. Check the result channel first, so a
  // transaction taken on this edge can never be matched against its own
  // expectation, then record the transaction accepted on this edge.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_result_q.size() == 0) begin
          $error("result with nothing expected: granted_id %0d status %0d count %0d",
                 out_granted_id, out_status, out_in_use_count);
          error_count++;
        end else begin
          exp_r = expected_result_q.pop_front();
          if (out_granted_id !== exp_r.granted) begin
            $error("granted_id: expected %0d, actual %0d", exp_r.granted, out_granted_id);
            error_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_status);
            error_count++;
          end
          if (out_in_use_count !== exp_r.count) begin
            $error("in_use_count: expected %0d, actual %0d", exp_r.count,
                   out_in_use_count);
            error_count++;
          end
          if (exp_r.status == ST_OK && exp_r.granted != '0) grant_count++;
          if (exp_r.status == ST_EXHAUSTED) exhausted_count++;
          if (exp_r.status == ST_NOT_IN_USE) not_in_use_count++;
          if (int'(exp_r.count) > peak_in_use) peak_in_use = int'(exp_r.count);
        end
      end else if (out_valid !== 1'b0) begin
        $error("out_valid: expected 0 or 1, actual %b", out_valid);
        error_count++;
      end
      if (start && busy === 1'b0) begin
        predict_request(in_op, in_id);
        accepted_count++;
        accept_seen = 1'b1;
      end
    end
  end

  initial begin
    // Directed opening: out-of-range and free releases on an empty map,
    // plain grants, reuse of a freed hole, double release, ignored id field.
    queue_request(OP_RELEASE, ID_W'(0));
    queue_request(OP_RELEASE, ID_W'(1));
    queue_request(OP_RELEASE, ID_W'(MAX_IDS));
    queue_request(OP_RELEASE, ID_W'(MAX_IDS + 1));
    queue_request(OP_RELEASE, '1);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '1);
    queue_request(OP_ALLOC, ID_W'(MAX_IDS));
    queue_request(OP_ALLOC, ID_W'(170));
    queue_request(OP_RELEASE, ID_W'(2));
    queue_request(OP_RELEASE, ID_W'(2));
    queue_request(OP_ALLOC, ID_W'(85));
    queue_request(OP_RELEASE, ID_W'(1));
    queue_request(OP_RELEASE, ID_W'(3));
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_RELEASE, ID_W'(4));
    queue_request(OP_RELEASE, ID_W'(0), 1'b1);
    // Random part: two rounds of fill, churn, drain and noise.
    queue_round();
    queue_round();
    total_requests = request_q.size();

    // Hold reset low at the start, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    wait (accepted_count == total_requests);
    while (expected_result_q.size() != 0) @(posedge clk);
    // Keep watching the outputs so a stray extra result would still be seen.
    repeat (12) @(posedge clk);

    $display("Ran %0d transactions: %0d grants, %0d exhausted allocates,",
             total_requests, grant_count, exhausted_count);
    $display("%0d refused releases, at most %0d of %0d IDs in use at once.",
             not_in_use_count, peak_in_use, MAX_IDS);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/lfid_pkg.sv
src/lfid_ctrl.sv
src/lfid_datapath.sv
src/lowest_free_id_allocator.sv
src/lfid_checker.sv
tb/tb_top.sv
